[src/lvw_pkg.sv]
package lvw_pkg;

   // Port coordinate width, fixed by the word layout
   localparam int CoordWidth = 6;

   typedef struct packed {
      logic [CoordWidth-1:0] begin_x;
      logic [CoordWidth-1:0] begin_y;
      logic [CoordWidth-1:0] begin_z;
      logic [CoordWidth-1:0] end_x;
      logic [CoordWidth-1:0] end_y;
      logic [CoordWidth-1:0] end_z;
   } req_word_type;

   typedef struct packed {
      logic [CoordWidth-1:0] point_x;
      logic [CoordWidth-1:0] point_y;
      logic [CoordWidth-1:0] point_z;
      logic                  last_point;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture a new line from the request word
      logic advance;  // step the walk to the next point
   } walk_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;     // the current point is the line's end point
   } walk_status_type;

endpackage

[src/lvw_ctrl.sv]
module lvw_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lvw_pkg::walk_cmd_type     cmd,
   input  lvw_pkg::walk_status_type  status
);
   import lvw_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_WALK);

   always_comb begin
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/lvw_datapath.sv]
module lvw_datapath #(
   parameter int COORD_BITS = 6
) (
   input  logic                      clock,
   input  lvw_pkg::req_word_type     req_word,
   input  lvw_pkg::walk_cmd_type     cmd,
   output lvw_pkg::rsp_word_type     rsp_word,
   output lvw_pkg::walk_status_type  status
);
   import lvw_pkg::*;

   localparam int ErrBits = COORD_BITS + 1;

   logic [COORD_BITS-1:0] begin_c [3];
   logic [COORD_BITS-1:0] end_c   [3];
   logic [COORD_BITS-1:0] delta_in [3];
   logic                  down_in  [3];
   logic [COORD_BITS-1:0] total_in;

   logic [COORD_BITS-1:0]     pos_ff   [3];
   logic [COORD_BITS-1:0]     pos_in   [3];
   logic signed [ErrBits-1:0] err_ff   [3];
   logic signed [ErrBits-1:0] err_in   [3];
   logic signed [ErrBits-1:0] err_sub  [3];
   logic [COORD_BITS-1:0]     delta_ff [3];
   logic                      down_ff  [3];
   logic [COORD_BITS-1:0]     total_ff;
   logic [COORD_BITS-1:0]     remain_ff;
   logic [COORD_BITS-1:0]     remain_in;

   // Drop coordinate bits above the grid
   assign begin_c[0] = req_word.begin_x[COORD_BITS-1:0];
   assign begin_c[1] = req_word.begin_y[COORD_BITS-1:0];
   assign begin_c[2] = req_word.begin_z[COORD_BITS-1:0];
   assign end_c[0]   = req_word.end_x[COORD_BITS-1:0];
   assign end_c[1]   = req_word.end_y[COORD_BITS-1:0];
   assign end_c[2]   = req_word.end_z[COORD_BITS-1:0];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (end_c[a] >= begin_c[a]) begin
            delta_in[a] = end_c[a] - begin_c[a];
            down_in[a]  = 1'b0;
         end else begin
            delta_in[a] = begin_c[a] - end_c[a];
            down_in[a]  = 1'b1;
         end
      end
      total_in = delta_in[0];
      if (delta_in[1] > total_in) total_in = delta_in[1];
      if (delta_in[2] > total_in) total_in = delta_in[2];
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         err_sub[a] = err_ff[a] - $signed({1'b0, delta_ff[a]});
         err_in[a]  = err_sub[a];
         pos_in[a]  = pos_ff[a];
         if (err_sub[a] < 0) begin
            err_in[a] = err_sub[a] + $signed({1'b0, total_ff});
            pos_in[a] = down_ff[a] ? pos_ff[a] - 1'b1 : pos_ff[a] + 1'b1;
         end
      end
      remain_in = remain_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[a]   <= begin_c[a];
            err_ff[a]   <= $signed({2'b00, total_in[COORD_BITS-1:1]});
            delta_ff[a] <= delta_in[a];
            down_ff[a]  <= down_in[a];
         end
         total_ff  <= total_in;
         remain_ff <= total_in;
      end else if (cmd.advance) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[a] <= pos_in[a];
            err_ff[a] <= err_in[a];
         end
         remain_ff <= remain_in;
      end
   end

   assign status.last = (remain_ff == '0);

   assign rsp_word.point_x    = CoordWidth'(pos_ff[0]);
   assign rsp_word.point_y    = CoordWidth'(pos_ff[1]);
   assign rsp_word.point_z    = CoordWidth'(pos_ff[2]);
   assign rsp_word.last_point = status.last;

endmodule

[src/line_voxel_walker_3d_unit.sv]
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_ready  begin and end points (x, y, z)
// rsp       out        rsp_valid / rsp_ready  one line point, last_point flag
//
// A line of N = max|delta| + 1 points is walked after the request word is
// loaded: one point per cycle while rsp_ready is high, set by the single
// per-axis error update loop in the datapath.
// One line at a time: req_ready is high only between lines.
// A low rsp_ready holds the current point and all walk state.
// Reset (synchronous, active high) returns the controller to idle.
module line_voxel_walker_3d_unit #(
   parameter int COORD_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lvw_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lvw_pkg::rsp_word_type rsp_word
);
   import lvw_pkg::*;

   walk_cmd_type    cmd;
   walk_status_type status;

   // Sequence loads and steps from the two handshakes
   lvw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Hold the current point, error terms and remaining step count
   lvw_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .rsp_word (rsp_word),
      .status   (status)
   );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import lvw_pkg::*;

   // Grid size handed to the block; predictor masks coordinates the same way
   localparam int GridBits  = 6;
   localparam int GridMask  = (1 << GridBits) - 1;
   // Watchdog: bound on the whole run of 220 lines of up to 64 points each, with
   // receiver stalls, sender gaps and hold-offs, and a wide margin on top
   localparam int CycleLimit = 1_500_000;
   localparam int RandomLines = 190;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   // Points still owed by the block, oldest first
   rsp_word_type expected_points[$];

   int  fail_count   = 0;
   int  lines_sent   = 0;
   int  points_seen  = 0;
   int  last_flags   = 0;
   int  input_stalls = 0;
   int  hold_offs    = 0;
   int  cycle_count  = 0;

   // Idle controls for the sender and the receiver
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   int  hold_off_req  = 0;
   int  hold_off_left = 0;
   int  stall_left    = 0;

   line_voxel_walker_3d_unit #(
      .COORD_BITS(GridBits)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Print one line per mismatch and count every one
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // Gap lengths: mostly short, now and then long
   function automatic int pick_len();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 20);
   endfunction

   function automatic int pick_gap();
      if (!tx_idle_on || $urandom_range(0, 9) < 6) begin
         return 0;
      end
      return pick_len();
   endfunction

   // Walk the line the way the block should: step count is the largest axis
   // delta, every axis error starts at half of it, subtract the axis delta per
   // point and, on going negative, add the step count back and move one voxel.
   task automatic plot_line(input req_word_type w);
      int           b[3];
      int           e[3];
      int           d[3];
      int           pos[3];
      int           err[3];
      bit           down[3];
      int           total;
      rsp_word_type pt;
      b[0] = w.begin_x & GridMask;
      b[1] = w.begin_y & GridMask;
      b[2] = w.begin_z & GridMask;
      e[0] = w.end_x & GridMask;
      e[1] = w.end_y & GridMask;
      e[2] = w.end_z & GridMask;
      total = 0;
      for (int a = 0; a < 3; a++) begin
         down[a] = (e[a] < b[a]);
         d[a]    = down[a] ? b[a] - e[a] : e[a] - b[a];
         if (d[a] > total) begin
            total = d[a];
         end
      end
      for (int a = 0; a < 3; a++) begin
         err[a] = total / 2;
         pos[a] = b[a];
      end
      for (int i = 0; i <= total; i++) begin
         pt.point_x    = CoordWidth'(pos[0]);
         pt.point_y    = CoordWidth'(pos[1]);
         pt.point_z    = CoordWidth'(pos[2]);
         pt.last_point = (i == total);
         expected_points = {expected_points, pt};
         for (int a = 0; a < 3; a++) begin
            err[a] -= d[a];
            if (err[a] < 0) begin
               err[a] += total;
               pos[a] = (down[a] ? pos[a] - 1 : pos[a] + 1) & GridMask;
            end
         end
      end
   endtask

   function automatic req_word_type make_word(input int bx, by, bz, ex, ey, ez);
      req_word_type w;
      w.begin_x = CoordWidth'(bx);
      w.begin_y = CoordWidth'(by);
      w.begin_z = CoordWidth'(bz);
      w.end_x   = CoordWidth'(ex);
      w.end_y   = CoordWidth'(ey);
      w.end_z   = CoordWidth'(ez);
      return w;
   endfunction

   // Offer one request word; hold valid and payload until accepted. Valid is
   // left high on return so back-to-back words never drop it within a step.
   task automatic send_line(input req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      plot_line(w);
      lines_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed point has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_points.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic req_word_type random_line();
      int c[6];
      int kind;
      int ax;
      int off;
      for (int i = 0; i < 6; i++) begin
         c[i] = $urandom_range(0, 63);
      end
      kind = $urandom_range(0, 9);
      case (kind)
         4, 5: begin
            // short line: end a few voxels away on each axis
            for (int i = 0; i < 3; i++) begin
               off = $urandom_range(0, 8) - 4;
               c[i + 3] = (c[i] + off) & 63;
            end
         end
         6: begin
            // axis aligned: only one axis moves
            ax = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
               if (i != ax) begin
                  c[i + 3] = c[i];
               end
            end
         end
         7: begin
            // grid corners
            for (int i = 0; i < 6; i++) begin
               c[i] = $urandom_range(0, 1) ? 63 : 0;
            end
         end
         8: begin
            // single point
            for (int i = 0; i < 3; i++) begin
               c[i + 3] = c[i];
            end
         end
         9: begin
            // one dominant axis, the others drift slightly
            ax = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
               if (i != ax) begin
                  c[i + 3] = (c[i] + $urandom_range(0, 6) - 3) & 63;
               end
            end
         end
         default: begin
         end
      endcase
      return make_word(c[0], c[1], c[2], c[3], c[4], c[5]);
   endfunction

   // Receiver: random stalls, plus long hold-offs requested by a test
   always @(negedge clock) begin
      if (hold_off_req > 0) begin
         hold_off_left = hold_off_req;
         hold_off_req  = 0;
         hold_offs++;
      end
      if (hold_off_left > 0) begin
         rsp_ready = 1'b0;
         hold_off_left--;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = pick_len();
         end
      end
   end

   // Checker: compare every accepted point with the oldest owed one
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_ready) begin
            input_stalls++;
         end
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (rsp_word.last_point) begin
               last_flags++;
            end
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected point (%0d,%0d,%0d) last=%0b",
                  rsp_word.point_x, rsp_word.point_y, rsp_word.point_z,
                  rsp_word.last_point));
            end else begin
               want = expected_points.pop_front();
               if (rsp_word.point_x !== want.point_x) begin
                  report_mismatch($sformatf("point_x got %0d want %0d",
                     rsp_word.point_x, want.point_x));
               end
               if (rsp_word.point_y !== want.point_y) begin
                  report_mismatch($sformatf("point_y got %0d want %0d",
                     rsp_word.point_y, want.point_y));
               end
               if (rsp_word.point_z !== want.point_z) begin
                  report_mismatch($sformatf("point_z got %0d want %0d",
                     rsp_word.point_z, want.point_z));
               end
               if (rsp_word.last_point !== want.last_point) begin
                  report_mismatch($sformatf("last_point got %0b want %0b at (%0d,%0d,%0d)",
                     rsp_word.last_point, want.last_point,
                     want.point_x, want.point_y, want.point_z));
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles, %0d points still owed",
            cycle_count, expected_points.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Extremes, single points, every direction per axis, ties between axes
   task automatic test_directed_lines();
      req_word_type w[$];
      w = {w, make_word(0, 0, 0, 0, 0, 0)};
      w = {w, make_word(63, 63, 63, 63, 63, 63)};
      w = {w, make_word(0, 0, 0, 63, 63, 63)};
      w = {w, make_word(63, 63, 63, 0, 0, 0)};
      w = {w, make_word(0, 0, 0, 63, 0, 0)};
      w = {w, make_word(0, 63, 0, 0, 0, 0)};
      w = {w, make_word(5, 5, 0, 5, 5, 63)};
      w = {w, make_word(63, 0, 0, 0, 0, 0)};
      w = {w, make_word(0, 0, 63, 0, 0, 0)};
      w = {w, make_word(10, 10, 10, 11, 10, 10)};
      w = {w, make_word(10, 10, 10, 10, 9, 10)};
      w = {w, make_word(10, 10, 10, 10, 10, 11)};
      w = {w, make_word(0, 63, 10, 63, 0, 40)};
      w = {w, make_word(63, 0, 63, 0, 63, 0)};
      w = {w, make_word(0, 0, 0, 63, 1, 62)};
      w = {w, make_word(1, 2, 3, 4, 6, 9)};
      w = {w, make_word(20, 20, 20, 30, 25, 30)};
      w = {w, make_word(42, 21, 7, 35, 30, 7)};
      w = {w, make_word(0, 0, 0, 1, 1, 1)};
      w = {w, make_word(32, 32, 32, 31, 33, 32)};
      w = {w, make_word(0, 0, 0, 2, 1, 0)};
      w = {w, make_word(0, 0, 0, 3, 1, 2)};
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      foreach (w[i]) begin
         send_line(w[i]);
      end
      wait_drained();
   endtask

   // Hold the receiver off so the block fills and stalls its input
   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      @(posedge clock);
      hold_off_req = 300;
      @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         send_line(random_line());
      end
      wait_drained();
   endtask

   // Random lines, with idling switched on and off in stretches and the
   // sender pausing for a full drain every so often
   task automatic test_random_lines();
      for (int i = 0; i < RandomLines; i++) begin
         if (i % 40 == 0) begin
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            if (i == 0) begin
               tx_idle_on = 1'b0;
               rx_idle_on = 1'b0;
            end
         end
         if (i % 55 == 54) begin
            wait_drained();
         end
         send_line(random_line());
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_lines();
      test_backpressure();
      test_random_lines();
      test_backpressure();

      // Hold for the load cycle and any trailing point
      repeat (10) @(posedge clock);
      if (expected_points.size() != 0) begin
         report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
      end

      $display("Walked %0d lines, checked %0d points (%0d line ends) in %0d cycles",
         lines_sent, points_seen, last_flags, cycle_count);
      $display("Receiver hold-offs: %0d, cycles with the input stalled: %0d",
         hold_offs, input_stalls);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
